// ----- hw/rtl/esms_pkg.sv -----
`timescale 1ns / 1ps

package esms_pkg;

  localparam int unsigned ResultDepth = 4;

  // Reset values of the configuration registers.
  localparam logic [15:0] ResetHoldDefault = 16'd50;
  localparam logic [7:0]  CodeIdleDefault  = 8'd0;
  localparam logic [7:0]  CodeErrorDefault = 8'd1;
  localparam logic [7:0]  CodeResetDefault = 8'd2;
  localparam logic [7:0]  CodeHaltDefault  = 8'd3;

  typedef enum logic [2:0] {
    MODE_NOCTRL  = 3'd0,
    MODE_DISABLE = 3'd1,
    MODE_ENABLE  = 3'd2,
    MODE_RESET   = 3'd3,
    MODE_ESTOP   = 3'd4,
    MODE_HALT    = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    EV_ACK_NOCTRL  = 4'd0,
    EV_ACK_DISABLE = 4'd1,
    EV_ACK_ENABLE  = 4'd2,
    EV_ACK_ESTOP   = 4'd3,
    EV_ACK_HALT    = 4'd4,
    EV_ACK_RESET   = 4'd5,
    EV_CTRL_ESTOP  = 4'd6,
    EV_CMD_ESTOP   = 4'd7,
    EV_BAD_CMD     = 4'd8,
    EV_BAD_MODE    = 4'd9
  } event_t;

  typedef enum logic [1:0] {
    LOAD_NONE   = 2'd0,
    LOAD_UNLOAD = 2'd1,
    LOAD_LOAD   = 2'd2
  } loader_t;

  typedef enum logic [2:0] {
    CFG_RESET_HOLD = 3'd0,
    CFG_CODE_IDLE  = 3'd1,
    CFG_CODE_ERROR = 3'd2,
    CFG_CODE_RESET = 3'd3,
    CFG_CODE_HALT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic       drive_valid;
    logic [7:0] drive_state;
    logic       event_valid;
    logic [3:0] event_code;
    logic [1:0] loader_action;
    logic       last_result;
  } result_t;

  function automatic result_t mk_event(event_t ev, loader_t la, logic last);
    result_t r;
    r = '0;
    r.event_valid   = 1'b1;
    r.event_code    = ev;
    r.loader_action = la;
    r.last_result   = last;
    return r;
  endfunction

endpackage

// ----- hw/rtl/estop_latched_mode_supervisor_top.sv -----
`timescale 1ns / 1ps
// An accepted request's results enter the result queue and leave it in order.
// One request is accepted per cycle while in_stall is low. The output delivers one
// result per cycle while out_stall is low; an estop command writes two results.
// A four-entry result queue sits between decision logic and output; in_stall rises
// when fewer than two entries are free. Reset: no-controller mode, tick count zero,
// registers at their defaults, result queue empty.
module estop_latched_mode_supervisor_top
  import esms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [2:0]  in_requested_state,
  input  logic [7:0]  in_controller_command,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_drive_valid,
  output logic [7:0]  out_drive_state,
  output logic        out_event_valid,
  output logic [3:0]  out_event_code,
  output logic [1:0]  out_loader_action,
  output logic        out_last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned PtrW = $clog2(ResultDepth);
  localparam int unsigned CntW = $clog2(ResultDepth + 1);

  logic [15:0] reset_hold_r;
  logic [7:0]  code_idle_r;
  logic [7:0]  code_error_r;
  logic [7:0]  code_reset_r;
  logic [7:0]  code_halt_r;

  mode_t       mode_r, mode_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  result_t     mem_r [ResultDepth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r, count_nxt;

  result_t     item0, item1;
  logic        two_items;
  logic        in_acc, out_pop;
  logic [16:0] tick_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count_r > CntW'(ResultDepth - 2));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_pop   = out_valid && !out_stall;
  assign tick_inc  = {1'b0, ticks_r} + 17'd1;

  // Latched estop: only a reset request leaves it.
  function automatic mode_t guard_mode(mode_t cur, mode_t req);
    return (cur == MODE_ESTOP && req != MODE_RESET) ? cur : req;
  endfunction

  always_comb begin
    mode_nxt  = mode_r;
    ticks_nxt = ticks_r;
    item0     = '0;
    item1     = mk_event(EV_ACK_ESTOP, LOAD_NONE, 1'b1);
    two_items = 1'b0;
    if (!in_operation) begin
      item0.drive_valid = 1'b1;
      item0.last_result = 1'b1;
      case (mode_r)
        MODE_ESTOP: begin
          item0.drive_state = code_error_r;
        end
        MODE_NOCTRL, MODE_DISABLE: begin
          item0.drive_state = code_idle_r;
        end
        MODE_RESET: begin
          if (tick_inc > {1'b0, reset_hold_r}) begin
            ticks_nxt         = '0;
            mode_nxt          = MODE_NOCTRL;
            item0.event_valid = 1'b1;
            item0.event_code  = EV_ACK_RESET;
          end else begin
            ticks_nxt = tick_inc[15:0];
          end
          item0.drive_state = code_reset_r;
        end
        MODE_ENABLE: begin
          if (in_controller_command == code_error_r) begin
            mode_nxt          = MODE_ESTOP;
            item0.event_valid = 1'b1;
            item0.event_code  = EV_CTRL_ESTOP;
          end
          item0.drive_state = in_controller_command;
        end
        MODE_HALT: begin
          item0.drive_state = code_halt_r;
        end
        default: begin
          mode_nxt          = MODE_ESTOP;
          item0.event_valid = 1'b1;
          item0.event_code  = EV_BAD_MODE;
          item0.drive_state = code_error_r;
        end
      endcase
    end else begin
      case (in_requested_state)
        MODE_NOCTRL: begin
          mode_nxt = guard_mode(mode_r, MODE_NOCTRL);
          item0    = mk_event(EV_ACK_NOCTRL, LOAD_UNLOAD, 1'b1);
        end
        MODE_DISABLE: begin
          mode_nxt = guard_mode(mode_r, MODE_DISABLE);
          item0    = mk_event(EV_ACK_DISABLE, LOAD_LOAD, 1'b1);
        end
        MODE_ENABLE: begin
          mode_nxt = guard_mode(mode_r, MODE_ENABLE);
          item0    = mk_event(EV_ACK_ENABLE, LOAD_NONE, 1'b1);
        end
        MODE_RESET: begin
          // Acknowledge comes when the reset completes.
          mode_nxt                = MODE_RESET;
          item0.loader_action     = LOAD_UNLOAD;
          item0.last_result       = 1'b1;
        end
        MODE_ESTOP: begin
          mode_nxt  = MODE_ESTOP;
          item0     = mk_event(EV_CMD_ESTOP, LOAD_NONE, 1'b0);
          two_items = 1'b1;
        end
        MODE_HALT: begin
          mode_nxt = guard_mode(mode_r, MODE_HALT);
          item0    = mk_event(EV_ACK_HALT, LOAD_NONE, 1'b1);
        end
        default: begin
          mode_nxt = MODE_ESTOP;
          item0    = mk_event(EV_BAD_CMD, LOAD_UNLOAD, 1'b1);
        end
      endcase
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc) begin
      count_nxt = count_nxt + (two_items ? CntW'(2) : CntW'(1));
    end
    if (out_pop) begin
      count_nxt = count_nxt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_hold_r <= ResetHoldDefault;
      code_idle_r  <= CodeIdleDefault;
      code_error_r <= CodeErrorDefault;
      code_reset_r <= CodeResetDefault;
      code_halt_r  <= CodeHaltDefault;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RESET_HOLD: reset_hold_r <= cfg_data;
        CFG_CODE_IDLE:  code_idle_r  <= cfg_data[7:0];
        CFG_CODE_ERROR: code_error_r <= cfg_data[7:0];
        CFG_CODE_RESET: code_reset_r <= cfg_data[7:0];
        CFG_CODE_HALT:  code_halt_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NOCTRL;
      ticks_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        mode_r   <= mode_nxt;
        ticks_r  <= ticks_nxt;
        wr_ptr_r <= wr_ptr_r + (two_items ? PtrW'(2) : PtrW'(1));
      end
      if (out_pop) begin
        rd_ptr_r <= rd_ptr_r + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_r[wr_ptr_r] <= item0;
      if (two_items) begin
        mem_r[wr_ptr_r + PtrW'(1)] <= item1;
      end
    end
  end

  assign out_drive_valid   = mem_r[rd_ptr_r].drive_valid;
  assign out_drive_state   = mem_r[rd_ptr_r].drive_state;
  assign out_event_valid   = mem_r[rd_ptr_r].event_valid;
  assign out_event_code    = mem_r[rd_ptr_r].event_code;
  assign out_loader_action = mem_r[rd_ptr_r].loader_action;
  assign out_last_result   = mem_r[rd_ptr_r].last_result;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(ResultDepth))
    else $error("result queue overfilled");

  a_count_track : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_pop) |=>
      count_r == $past(count_r) + ($past(two_items) ? CntW'(2) : CntW'(1)))
    else $error("result count lost a request");

  a_estop_latch : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && mode_r == MODE_ESTOP &&
     !(in_operation && in_requested_state == MODE_RESET)) |=> mode_r == MODE_ESTOP)
    else $error("emergency stop left without reset request");

  a_reset_ticks : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_operation && mode_r == MODE_RESET &&
     tick_inc > {1'b0, reset_hold_r}) |=> (mode_r == MODE_NOCTRL && ticks_r == '0))
    else $error("reset phase did not complete");

endmodule
